[sv/tsvf_pkg.sv]
package tsvf_pkg;

  // default widths of the sample path and of the integrator states
  localparam int unsigned SampleWidthDef = 24;
  localparam int unsigned StateWidthDef  = 32;

  // coefficient formats
  localparam int unsigned CoefW    = 24;
  localparam int unsigned CoefFrac = 23;  // a1..a3, Q1.23
  localparam int unsigned DampFrac = 19;  // k, Q5.19
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [CoefW-1:0] A1Reset = 24'h800000;  // 1.0
  localparam logic [CoefW-1:0] KReset  = 24'h080000;  // 1.0

  typedef enum logic [CfgIdxW-1:0] {
    REG_A1   = 3'd0,
    REG_A2   = 3'd1,
    REG_A3   = 3'd2,
    REG_K    = 3'd3,
    REG_MODE = 3'd4
  } cfg_reg_e;

  typedef enum logic [ModeW-1:0] {
    MODE_LP    = 2'd0,
    MODE_BP    = 2'd1,
    MODE_HP    = 2'd2,
    MODE_NOTCH = 2'd3
  } filt_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5,
    ST_P6,
    ST_P7
  } seq_state_e;

  // control of the shared multiply/round unit
  typedef struct packed {
    logic en;    // advance both pipeline stages
    logic damp;  // round at the damping position instead of the coefficient one
  } mul_ctl_t;

endpackage

[sv/tsvf_mul_unit.sv]
module tsvf_mul_unit #(
  parameter int unsigned OP_W = tsvf_pkg::StateWidthDef + 1
) (
  input  logic                                                      clk_i,
  input  tsvf_pkg::mul_ctl_t                                        ctl_i,
  input  logic signed [OP_W-1:0]                                    op_i,
  input  logic        [tsvf_pkg::CoefW-1:0]                         coef_i,
  output logic signed [OP_W+tsvf_pkg::CoefW-tsvf_pkg::DampFrac:0] rnd_o
);
  import tsvf_pkg::*;

  localparam int unsigned PW = OP_W + CoefW + 1;
  localparam int unsigned RW = PW - DampFrac;

  logic signed [PW-1:0] prod_q, prod_d;
  logic                 damp_q;
  logic signed [PW-1:0] sum_c;
  logic signed [RW-1:0] rnd_q, rnd_d;

  // stage 1: signed operand times unsigned coefficient
  assign prod_d = PW'(op_i) * PW'($signed({1'b0, coef_i}));

  // stage 2: add half an LSB and floor
  always_comb begin
    if (damp_q) begin
      sum_c = prod_q + (PW'(1) <<< (DampFrac - 1));
      rnd_d = RW'(sum_c >>> DampFrac);
    end else begin
      sum_c = prod_q + (PW'(1) <<< (CoefFrac - 1));
      rnd_d = RW'(sum_c >>> CoefFrac);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      prod_q <= prod_d;
      damp_q <= ctl_i.damp;
      rnd_q  <= rnd_d;
    end
  end

  assign rnd_o = rnd_q;

endmodule

[sv/trapezoidal_state_variable_filter_unit.sv]
// Trapezoidal state variable filter, one shared multiply/round unit.
// A new sample is taken only while the sequencer is idle, so one sample is
// finished before the next is accepted; five products go one after another
// through the two-stage multiply/round unit.
// Reset (async, active low): integrators cleared, coefficients to a1 = 1.0,
// a2 = a3 = 0, k = 1.0, mode lowpass; output register empty.
module trapezoidal_state_variable_filter_unit #(
  parameter int unsigned SAMPLE_WIDTH = tsvf_pkg::SampleWidthDef,
  parameter int unsigned STATE_WIDTH  = tsvf_pkg::StateWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [tsvf_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [tsvf_pkg::CoefW-1:0]           cfg_data_i,
  // input samples
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // [SAMPLE_WIDTH-1:0]
  // filtered samples
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata   // [SAMPLE_WIDTH-1:0]
);
  import tsvf_pkg::*;

  localparam int unsigned DW   = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned SW   = STATE_WIDTH;
  localparam int unsigned AW   = SW + 1;                       // v3 = x - ic2
  localparam int unsigned RW   = AW + CoefW + 1 - DampFrac;    // rounded product
  localparam int unsigned ACCW = SW + 8;                       // sums before saturation

  localparam logic signed [ACCW-1:0] StMax = {{(ACCW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [ACCW-1:0] StMin = {{(ACCW-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [ACCW-1:0] SmpMax =
    {{(ACCW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACCW-1:0] SmpMin =
    {{(ACCW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  function automatic logic signed [SW-1:0] sat_state(input logic signed [ACCW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > StMax)      r = StMax[SW-1:0];
    else if (v < StMin) r = StMin[SW-1:0];
    else                r = v[SW-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [ACCW-1:0] v
  );
    logic signed [SAMPLE_WIDTH-1:0] r;
    if (v > SmpMax)      r = SmpMax[SAMPLE_WIDTH-1:0];
    else if (v < SmpMin) r = SmpMin[SAMPLE_WIDTH-1:0];
    else                 r = v[SAMPLE_WIDTH-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CoefW-1:0] a1_q, a2_q, a3_q, k_q;
  filt_mode_e       mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q   <= A1Reset;
      a2_q   <= '0;
      a3_q   <= '0;
      k_q    <= KReset;
      mode_q <= MODE_LP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_A1:   a1_q   <= cfg_data_i;
        REG_A2:   a2_q   <= cfg_data_i;
        REG_A3:   a3_q   <= cfg_data_i;
        REG_K:    k_q    <= cfg_data_i;
        REG_MODE: mode_q <= filt_mode_e'(cfg_data_i[ModeW-1:0]);
        default:  ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // Schedule (each product is registered in prod_q, then rounded into rnd_q):
  //   P1 a1*ic1 | P2 a2*v3 | P3 a2*ic1, acc=p1 | P4 a3*v3, v1=sat(acc+p2)
  //   P5 k*v1, acc=ic2+p3, ic1 update | P6 v2=sat(acc+p4)
  //   P7 output from k*v1, ic2 update; waits here while the output is full
  // ---------------------------------------------------------------------------
  seq_state_e state_q, state_d;
  logic       out_free;
  logic       s_acc;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_P1;
      ST_P1:   state_d = ST_P2;
      ST_P2:   state_d = ST_P3;
      ST_P3:   state_d = ST_P4;
      ST_P4:   state_d = ST_P5;
      ST_P5:   state_d = ST_P6;
      ST_P6:   state_d = ST_P7;
      ST_P7:   if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // ---------------------------------------------------------------------------
  // operand selection for the shared unit
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [SW-1:0]           ic1_q, ic2_q, v1_q, v2_q;
  logic signed [ACCW-1:0]         acc_q;
  logic signed [AW-1:0]           v3_c;
  logic signed [AW-1:0]           op_c;
  logic        [CoefW-1:0]        coef_c;
  mul_ctl_t                       mul_ctl;
  logic signed [RW-1:0]           prod_r;

  assign v3_c = AW'(x_q) - AW'(ic2_q);

  always_comb begin
    op_c         = AW'(ic1_q);
    coef_c       = a1_q;
    mul_ctl.en   = 1'b1;
    mul_ctl.damp = 1'b0;
    unique case (state_q)
      ST_P1: begin op_c = AW'(ic1_q); coef_c = a1_q; end
      ST_P2: begin op_c = v3_c;       coef_c = a2_q; end
      ST_P3: begin op_c = AW'(ic1_q); coef_c = a2_q; end
      ST_P4: begin op_c = v3_c;       coef_c = a3_q; end
      ST_P5: begin
        op_c         = AW'(v1_q);
        coef_c       = k_q;
        mul_ctl.damp = 1'b1;
      end
      ST_P7:   mul_ctl.en = 1'b0;  // hold k*v1 while the output waits
      default: ;
    endcase
  end

  tsvf_mul_unit #(
    .OP_W (AW)
  ) u_mul (
    .clk_i  (clk_i),
    .ctl_i  (mul_ctl),
    .op_i   (op_c),
    .coef_i (coef_c),
    .rnd_o  (prod_r)
  );

  // ---------------------------------------------------------------------------
  // accumulation and state update
  // ---------------------------------------------------------------------------
  logic signed [ACCW-1:0] prod_x;
  logic signed [ACCW-1:0] y_c;

  assign prod_x = ACCW'(prod_r);

  always_comb begin
    unique case (mode_q)
      MODE_LP:    y_c = ACCW'(v2_q);
      MODE_BP:    y_c = ACCW'(v1_q);
      MODE_HP:    y_c = ACCW'(x_q) - prod_x - ACCW'(v2_q);
      MODE_NOTCH: y_c = ACCW'(x_q) - prod_x;
      default:    y_c = ACCW'(v2_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) x_q <= s_axis_tdata[SAMPLE_WIDTH-1:0];
    unique case (state_q)
      ST_P3:   acc_q <= prod_x;
      ST_P4:   v1_q  <= sat_state(acc_q + prod_x);
      ST_P5:   acc_q <= ACCW'(ic2_q) + prod_x;
      ST_P6:   v2_q  <= sat_state(acc_q + prod_x);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic1_q <= '0;
      ic2_q <= '0;
    end else begin
      if (state_q == ST_P5) ic1_q <= sat_state((ACCW'(v1_q) <<< 1) - ACCW'(ic1_q));
      if (state_q == ST_P7 && out_free)
        ic2_q <= sat_state((ACCW'(v2_q) <<< 1) - ACCW'(ic2_q));
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic out_load;
  assign out_load = (state_q == ST_P7) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) m_axis_tdata <= DW'($unsigned(sat_sample(y_c)));
  end

`ifndef NO_ASSERTIONS
  // a taken request keeps the input side closed on the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input ready while a sample is in work");

  // leaving the last step always presents a result
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("result not presented after last step");

  // integrator one only moves on its update step
  a_ic1_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_P5) |=> $stable(ic1_q))
    else $error("integrator one changed outside its update step");

  // integrator two only moves when the result is loaded
  a_ic2_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(ic2_q))
    else $error("integrator two changed outside its update step");
`endif

endmodule
